### rtl/levelized_netlist_evaluator_top_assert.svh
// Assertion macros for the levelized netlist evaluator.
// Included by levelized_netlist_evaluator_top; no other dependencies.
`ifndef LEVELIZED_NETLIST_EVALUATOR_TOP_ASSERT_SVH
`define LEVELIZED_NETLIST_EVALUATOR_TOP_ASSERT_SVH

// Plain property check, clocked and disabled during reset.
`define LNE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication check.
`define LNE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/lne_pkg.sv
// Shared types and constants for the levelized netlist evaluator.
// No dependencies.
package lne_pkg;

  localparam int unsigned MAX_GATE_RECORDS   = 1024;
  localparam int unsigned MAX_FANIN          = 8;
  localparam int unsigned MAX_FANOUT         = 8;
  localparam int unsigned MAX_PRIMARY_INPUTS = 64;

  localparam int unsigned NODE_W     = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_LENGTH = 1'd1;

  // item actions
  localparam logic [2:0] ACT_KIND       = 3'd0;
  localparam logic [2:0] ACT_FANIN_PIN  = 3'd1;
  localparam logic [2:0] ACT_FANOUT_CNT = 3'd2;
  localparam logic [2:0] ACT_FANOUT_PIN = 3'd3;
  localparam logic [2:0] ACT_ORDER      = 3'd4;
  localparam logic [2:0] ACT_INPUT_MAP  = 3'd5;
  localparam logic [2:0] ACT_EVALUATE   = 3'd6;
  localparam logic [2:0] ACT_READ       = 3'd7;

  // gate kinds
  localparam logic [2:0] KIND_AND  = 3'd0;
  localparam logic [2:0] KIND_OR   = 3'd1;
  localparam logic [2:0] KIND_NAND = 3'd2;
  localparam logic [2:0] KIND_NOR  = 3'd3;
  localparam logic [2:0] KIND_XOR  = 3'd4;
  localparam logic [2:0] KIND_NOT  = 3'd5;

  typedef struct packed {
    logic [2:0]        action;
    logic [NODE_W-1:0] gate_index;
    logic [2:0]        pin_index;
    logic [NODE_W-1:0] node_index;
    logic [2:0]        gate_kind;
    logic [3:0]        pin_count;
    logic [9:0]        slot_index;
    logic [63:0]       input_vector;
  } in_item_t;

  typedef struct packed {
    logic node_value;
    logic status;
  } out_item_t;

endpackage

### rtl/lne_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lne_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/levelized_netlist_evaluator_top.sv
// Levelized netlist evaluator: netlist tables in RAM, walked by one small sequencer.
// Every item returns one result item. An evaluate drives each mapped
// primary input, then evaluates the gates in order; a drive writes the node and, if
// its fanout count exceeds 1, each fanout node. Each table has one RAM read port.
// One item at a time. After reset a pass clears node values; no items are taken during it.
// Depends on lne_pkg, lne_ram and levelized_netlist_evaluator_top_assert.svh.
`include "levelized_netlist_evaluator_top_assert.svh"

module levelized_netlist_evaluator_top #(
  parameter int unsigned MaxGateRecords   = lne_pkg::MAX_GATE_RECORDS,
  parameter int unsigned MaxFanin         = lne_pkg::MAX_FANIN,
  parameter int unsigned MaxFanout        = lne_pkg::MAX_FANOUT,
  parameter int unsigned MaxPrimaryInputs = lne_pkg::MAX_PRIMARY_INPUTS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  lne_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output lne_pkg::out_item_t               out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lne_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lne_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import lne_pkg::*;

  localparam int unsigned AW  = $clog2(MaxGateRecords);
  localparam int unsigned CW  = $clog2(MaxFanin + 1);
  localparam int unsigned PW  = $clog2(MaxFanin);
  localparam int unsigned OCW = $clog2(MaxFanout + 1);
  localparam int unsigned OPW = $clog2(MaxFanout);
  localparam int unsigned IW  = (MaxPrimaryInputs > 1) ? $clog2(MaxPrimaryInputs) : 1;
  localparam int unsigned XW0 = $clog2(MaxGateRecords + 1);
  localparam int unsigned XW  = (XW0 > 7) ? XW0 : 7;
  localparam int unsigned FinDepth = MaxGateRecords * (2 ** PW);
  localparam int unsigned FonDepth = MaxGateRecords * (2 ** OPW);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DONE = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_IN0  = 4'd4;
  localparam logic [3:0] S_IN1  = 4'd5;
  localparam logic [3:0] S_DRV  = 4'd6;
  localparam logic [3:0] S_DCNT = 4'd7;
  localparam logic [3:0] S_DRD  = 4'd8;
  localparam logic [3:0] S_DWR  = 4'd9;
  localparam logic [3:0] S_G0   = 4'd10;
  localparam logic [3:0] S_G1   = 4'd11;
  localparam logic [3:0] S_G2   = 4'd12;
  localparam logic [3:0] S_P0   = 4'd13;
  localparam logic [3:0] S_P1   = 4'd14;
  localparam logic [3:0] S_P2   = 4'd15;

  // control state
  logic [3:0]     state_q, state_d;
  logic [XW-1:0]  idx_q, idx_d;
  logic           phase_q, phase_d;     // 0: primary inputs, 1: gates
  logic           out_valid_q, out_valid_d;
  logic [6:0]     input_count_q;
  logic [10:0]    order_length_q;
  logic [CW-1:0]  p_q, p_d, pcnt_q, pcnt_d;
  logic [OCW-1:0] j_q, j_d, drv_cnt_q, drv_cnt_d;

  // payload state
  in_item_t       item_q, item_d;
  out_item_t      out_q, out_d;
  logic [AW-1:0]  gate_q, gate_d, drv_node_q, drv_node_d;
  logic [2:0]     kind_q, kind_d;
  logic           acc_and_q, acc_and_d, acc_or_q, acc_or_d, acc_xor_q, acc_xor_d;
  logic           nd_ok_q, nd_ok_d, drv_val_q, drv_val_d;
  logic           value_q, value_d, status_q, status_d;

  // RAM ports
  logic                   kind_we, fin_we, fcnt_we, fon_we, ord_we, map_we, node_we;
  logic [AW-1:0]          kind_waddr, fcnt_waddr, ord_waddr, node_waddr, node_raddr;
  logic [AW+PW-1:0]       fin_waddr;
  logic [AW+OPW-1:0]      fon_waddr;
  logic [IW-1:0]          map_waddr;
  logic [3+CW-1:0]        kind_wdata, kind_rdata;
  logic [OCW-1:0]         fcnt_wdata, fcnt_rdata;
  logic                   node_wdata, node_rdata;
  logic [NODE_W-1:0]      fin_rdata, fon_rdata, ord_rdata, map_rdata;

  logic           accept;
  logic           grec;
  logic [6:0]     lim_in;
  logic [10:0]    lim_ord;
  logic [XW-1:0]  idx_nx;
  logic [CW-1:0]  p_nx;
  logic [OCW-1:0] j_nx;
  logic           v, na, no, nx, res;
  logic [CW-1:0]  cnt_rd;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign grec    = int'(in_item_i.gate_index) < MaxGateRecords;
  assign lim_in  = (int'(input_count_q) > MaxPrimaryInputs) ? 7'(MaxPrimaryInputs)
                                                             : input_count_q;
  assign lim_ord = (int'(order_length_q) > MaxGateRecords) ? 11'(MaxGateRecords)
                                                            : order_length_q;
  assign idx_nx  = idx_q + XW'(1);
  assign p_nx    = p_q + CW'(1);
  assign j_nx    = j_q + OCW'(1);

  // table writes straight from the accepted item
  assign kind_we    = accept && (in_item_i.action == ACT_KIND) && grec;
  assign kind_waddr = AW'(in_item_i.gate_index);
  assign kind_wdata = {in_item_i.gate_kind,
                       (int'(in_item_i.pin_count) > MaxFanin) ? CW'(MaxFanin)
                                                               : CW'(in_item_i.pin_count)};
  assign fin_we     = accept && (in_item_i.action == ACT_FANIN_PIN) && grec &&
                      (int'(in_item_i.pin_index) < MaxFanin);
  assign fin_waddr  = {AW'(in_item_i.gate_index), PW'(in_item_i.pin_index)};
  assign fcnt_we    = accept && (in_item_i.action == ACT_FANOUT_CNT) && grec;
  assign fcnt_waddr = AW'(in_item_i.gate_index);
  assign fcnt_wdata = (int'(in_item_i.pin_count) > MaxFanout) ? OCW'(MaxFanout)
                                                               : OCW'(in_item_i.pin_count);
  assign fon_we     = accept && (in_item_i.action == ACT_FANOUT_PIN) && grec &&
                      (int'(in_item_i.pin_index) < MaxFanout);
  assign fon_waddr  = {AW'(in_item_i.gate_index), OPW'(in_item_i.pin_index)};
  assign ord_we     = accept && (in_item_i.action == ACT_ORDER) &&
                      (int'(in_item_i.slot_index) < MaxGateRecords);
  assign ord_waddr  = AW'(in_item_i.slot_index);
  assign map_we     = accept && (in_item_i.action == ACT_INPUT_MAP) &&
                      (int'(in_item_i.slot_index) < MaxPrimaryInputs);
  assign map_waddr  = IW'(in_item_i.slot_index);

  // node value writes: clearing pass or drive
  always_comb begin
    node_we    = 1'b0;
    node_waddr = drv_node_q;
    node_wdata = drv_val_q;
    case (state_q)
      S_CLR: begin
        node_we    = 1'b1;
        node_waddr = idx_q[AW-1:0];
        node_wdata = 1'b0;
      end
      S_DRV: node_we = 1'b1;
      S_DWR: begin
        node_we    = int'(fon_rdata) < MaxGateRecords;
        node_waddr = AW'(fon_rdata);
      end
      default: node_we = 1'b0;
    endcase
  end

  assign node_raddr = (state_q == S_IDLE) ? AW'(in_item_i.gate_index) : AW'(fin_rdata);
  assign cnt_rd     = kind_rdata[CW-1:0];

  lne_ram #(.Width(3 + CW), .Depth(MaxGateRecords)) u_kind_ram (
    .clk_i, .we_i(kind_we), .waddr_i(kind_waddr), .wdata_i(kind_wdata),
    .raddr_i(AW'(ord_rdata)), .rdata_o(kind_rdata));

  lne_ram #(.Width(NODE_W), .Depth(FinDepth)) u_fanin_ram (
    .clk_i, .we_i(fin_we), .waddr_i(fin_waddr), .wdata_i(in_item_i.node_index),
    .raddr_i({gate_q, p_q[PW-1:0]}), .rdata_o(fin_rdata));

  lne_ram #(.Width(OCW), .Depth(MaxGateRecords)) u_fanout_cnt_ram (
    .clk_i, .we_i(fcnt_we), .waddr_i(fcnt_waddr), .wdata_i(fcnt_wdata),
    .raddr_i(drv_node_q), .rdata_o(fcnt_rdata));

  lne_ram #(.Width(NODE_W), .Depth(FonDepth)) u_fanout_ram (
    .clk_i, .we_i(fon_we), .waddr_i(fon_waddr), .wdata_i(in_item_i.node_index),
    .raddr_i({drv_node_q, j_q[OPW-1:0]}), .rdata_o(fon_rdata));

  lne_ram #(.Width(NODE_W), .Depth(MaxGateRecords)) u_order_ram (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr), .wdata_i(in_item_i.node_index),
    .raddr_i(idx_q[AW-1:0]), .rdata_o(ord_rdata));

  lne_ram #(.Width(NODE_W), .Depth(MaxPrimaryInputs)) u_map_ram (
    .clk_i, .we_i(map_we), .waddr_i(map_waddr), .wdata_i(in_item_i.node_index),
    .raddr_i(idx_q[IW-1:0]), .rdata_o(map_rdata));

  lne_ram #(.Width(1), .Depth(MaxGateRecords)) u_node_ram (
    .clk_i, .we_i(node_we), .waddr_i(node_waddr), .wdata_i(node_wdata),
    .raddr_i(node_raddr), .rdata_o(node_rdata));

  // sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    p_d         = p_q;
    pcnt_d      = pcnt_q;
    j_d         = j_q;
    drv_cnt_d   = drv_cnt_q;
    item_d      = item_q;
    out_d       = out_q;
    gate_d      = gate_q;
    drv_node_d  = drv_node_q;
    kind_d      = kind_q;
    acc_and_d   = acc_and_q;
    acc_or_d    = acc_or_q;
    acc_xor_d   = acc_xor_q;
    nd_ok_d     = nd_ok_q;
    drv_val_d   = drv_val_q;
    value_d     = value_q;
    status_d    = status_q;
    v   = nd_ok_q & node_rdata;
    na  = acc_and_q & v;
    no  = acc_or_q | v;
    nx  = acc_xor_q ^ v;
    res = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLR: begin
        idx_d = idx_nx;
        if (int'(idx_nx) >= MaxGateRecords) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          item_d   = in_item_i;
          value_d  = 1'b0;
          status_d = 1'b0;
          idx_d    = '0;
          case (in_item_i.action)
            ACT_EVALUATE: begin
              phase_d = (lim_in == 7'd0);
              state_d = (lim_in == 7'd0) ? S_G0 : S_IN0;
            end
            ACT_READ: state_d = S_RD;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_RD: begin
        value_d = (int'(item_q.gate_index) < MaxGateRecords) && node_rdata;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d      = 1'b1;
          out_d.node_value = value_q;
          out_d.status     = status_q;
          state_d          = S_IDLE;
        end
      end
      S_IN0: state_d = S_IN1;
      S_IN1: begin
        drv_val_d  = item_q.input_vector[idx_q[5:0]];
        drv_node_d = AW'(map_rdata);
        if (int'(map_rdata) < MaxGateRecords) begin
          state_d = S_DRV;
        end else begin
          state_d = S_IN0;  // out-of-range node: skip, moved on below
        end
      end
      S_DRV:  state_d = S_DCNT;
      S_DCNT: begin
        drv_cnt_d = fcnt_rdata;
        j_d       = '0;
        if (fcnt_rdata > OCW'(1)) begin
          state_d = S_DRD;
        end
      end
      S_DRD: state_d = S_DWR;
      S_DWR: begin
        j_d = j_nx;
        if (j_nx < drv_cnt_q) begin
          state_d = S_DRD;
        end
      end
      S_G0: begin
        if (int'(idx_q) < int'(lim_ord)) begin
          state_d = S_G1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_G1: begin
        gate_d = AW'(ord_rdata);
        if (int'(ord_rdata) < MaxGateRecords) begin
          state_d = S_G2;
        end else begin
          idx_d   = idx_nx;
          state_d = S_G0;
        end
      end
      S_G2: begin
        kind_d    = kind_rdata[3+CW-1:CW];
        p_d       = '0;
        acc_and_d = 1'b1;
        acc_or_d  = 1'b0;
        acc_xor_d = 1'b0;
        if (kind_rdata[3+CW-1:CW] > KIND_NOT) begin
          status_d = 1'b1;
          idx_d    = idx_nx;
          state_d  = S_G0;
        end else begin
          if (kind_rdata[3+CW-1:CW] == KIND_NOT) begin
            pcnt_d = CW'(1);
          end else begin
            pcnt_d = (cnt_rd < CW'(2)) ? CW'(2) : cnt_rd;
          end
          state_d = S_P0;
        end
      end
      S_P0: state_d = S_P1;
      S_P1: begin
        nd_ok_d = int'(fin_rdata) < MaxGateRecords;
        state_d = S_P2;
      end
      S_P2: begin
        acc_and_d = na;
        acc_or_d  = no;
        acc_xor_d = nx;
        p_d       = p_nx;
        if (p_nx < pcnt_q) begin
          state_d = S_P0;
        end else begin
          case (kind_q)
            KIND_AND:  res = na;
            KIND_OR:   res = no;
            KIND_NAND: res = ~na;
            KIND_NOR:  res = ~no;
            KIND_XOR:  res = nx;
            KIND_NOT:  res = ~na;  // single pin
            default:   res = 1'b0;
          endcase
          drv_val_d  = res;
          drv_node_d = gate_q;
          state_d    = S_DRV;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // end of one drive (or a skipped input): step to the next input or gate
    if ((state_q == S_IN1 && int'(map_rdata) >= MaxGateRecords) ||
        (state_q == S_DCNT && fcnt_rdata <= OCW'(1)) ||
        (state_q == S_DWR && j_nx >= drv_cnt_q)) begin
      if (!phase_q) begin
        if (int'(idx_nx) < int'(lim_in)) begin
          idx_d   = idx_nx;
          state_d = S_IN0;
        end else begin
          idx_d   = '0;
          phase_d = 1'b1;
          state_d = S_G0;
        end
      end else begin
        idx_d   = idx_nx;
        state_d = S_G0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLR;
      idx_q          <= '0;
      phase_q        <= 1'b0;
      out_valid_q    <= 1'b0;
      p_q            <= '0;
      pcnt_q         <= '0;
      j_q            <= '0;
      drv_cnt_q      <= '0;
      input_count_q  <= '0;
      order_length_q <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      p_q         <= p_d;
      pcnt_q      <= pcnt_d;
      j_q         <= j_d;
      drv_cnt_q   <= drv_cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_INPUT_COUNT:  input_count_q  <= cfg_data_i[6:0];
          REG_ORDER_LENGTH: order_length_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    out_q      <= out_d;
    gate_q     <= gate_d;
    drv_node_q <= drv_node_d;
    kind_q     <= kind_d;
    acc_and_q  <= acc_and_d;
    acc_or_q   <= acc_or_d;
    acc_xor_q  <= acc_xor_d;
    nd_ok_q    <= nd_ok_d;
    drv_val_q  <= drv_val_d;
    value_q    <= value_d;
    status_q   <= status_d;
  end

  `LNE_ASSERT_IMPL(a_clear_blocks_items, clk_i, rst_ni, state_q == S_CLR, in_stall_o, "item taken during clear")
  `LNE_ASSERT_IMPL(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == S_DONE, "result outside done")
  `LNE_ASSERT_IMPL(a_fanout_bound, clk_i, rst_ni, state_q == S_DRD, j_q < drv_cnt_q, "fanout walk overrun")
  `LNE_ASSERT(a_fanin_bound, clk_i, rst_ni, (state_q != S_P0) || ((p_q < pcnt_q) && (int'(p_q) < MaxFanin)), "fanin walk overrun")

endmodule

### verif/levelized_netlist_evaluator_top_test.sv
// Self-checking testbench for levelized_netlist_evaluator_top: loads netlists, evaluates,
// reads node values and checks every result against an in-bench predictor.
// Depends on lne_pkg and the RTL of levelized_netlist_evaluator_top.
`timescale 1ns / 100ps

module levelized_netlist_evaluator_top_test;
  import lne_pkg::*;

  localparam logic [2:0] KIND_BAD_LO = 3'd6;
  localparam logic [2:0] KIND_BAD_HI = 3'd7;
  localparam int ITEM_BUDGET = 110;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  levelized_netlist_evaluator_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of the netlist tables, with written flags
  bit [2:0]  kinds     [MAX_GATE_RECORDS];
  bit [3:0]  fin_cnt   [MAX_GATE_RECORDS];
  bit [9:0]  fin_node  [MAX_GATE_RECORDS*MAX_FANIN];
  bit [3:0]  fout_cnt  [MAX_GATE_RECORDS];
  bit [9:0]  fout_node [MAX_GATE_RECORDS*MAX_FANOUT];
  bit        net_val   [MAX_GATE_RECORDS];
  bit [9:0]  order     [MAX_GATE_RECORDS];
  bit [9:0]  in_map    [MAX_PRIMARY_INPUTS];
  bit        kind_ok   [MAX_GATE_RECORDS];
  bit        fin_ok    [MAX_GATE_RECORDS*MAX_FANIN];
  bit        fcnt_ok   [MAX_GATE_RECORDS];
  bit        fout_ok   [MAX_GATE_RECORDS*MAX_FANOUT];
  bit        order_ok  [MAX_GATE_RECORDS];
  bit        map_ok    [MAX_PRIMARY_INPUTS];
  bit [6:0]  cfg_inputs;
  bit [10:0] cfg_order_len;

  out_item_t pending_results[$];
  int errors;
  int sent_items;
  int burst_left;

  function automatic void drive_node(int n, bit v);
    int c;
    net_val[n] = v;
    c = fout_cnt[n];
    if (c > 1) for (int j = 0; j < c; j++) net_val[fout_node[n*MAX_FANOUT+j]] = v;
  endfunction

  function automatic out_item_t netlist_response(in_item_t it);
    out_item_t r;
    int gi, slot, lim, c, g;
    bit a, o, x, v;
    r = '0;
    gi = it.gate_index;
    slot = it.slot_index;
    case (it.action)
      ACT_KIND: begin
        kinds[gi] = it.gate_kind;
        fin_cnt[gi] = (it.pin_count > MAX_FANIN) ? 4'(MAX_FANIN) : it.pin_count;
        kind_ok[gi] = 1;
      end
      ACT_FANIN_PIN: begin
        fin_node[gi*MAX_FANIN+it.pin_index] = it.node_index;
        fin_ok[gi*MAX_FANIN+it.pin_index] = 1;
      end
      ACT_FANOUT_CNT: begin
        fout_cnt[gi] = (it.pin_count > MAX_FANOUT) ? 4'(MAX_FANOUT) : it.pin_count;
        fcnt_ok[gi] = 1;
      end
      ACT_FANOUT_PIN: begin
        fout_node[gi*MAX_FANOUT+it.pin_index] = it.node_index;
        fout_ok[gi*MAX_FANOUT+it.pin_index] = 1;
      end
      ACT_ORDER: begin
        order[slot] = it.node_index;
        order_ok[slot] = 1;
      end
      ACT_INPUT_MAP: begin
        if (slot < MAX_PRIMARY_INPUTS) begin
          in_map[slot] = it.node_index;
          map_ok[slot] = 1;
        end
      end
      ACT_EVALUATE: begin
        lim = (cfg_inputs > MAX_PRIMARY_INPUTS) ? MAX_PRIMARY_INPUTS : cfg_inputs;
        for (int i = 0; i < lim; i++) drive_node(in_map[i], it.input_vector[i]);
        lim = (cfg_order_len > MAX_GATE_RECORDS) ? MAX_GATE_RECORDS : cfg_order_len;
        for (int i = 0; i < lim; i++) begin
          g = order[i];
          c = (fin_cnt[g] < 2) ? 2 : fin_cnt[g];
          a = 1; o = 0; x = 0;
          for (int p = 0; p < c; p++) begin
            v = net_val[fin_node[g*MAX_FANIN+p]];
            a &= v; o |= v; x ^= v;
          end
          case (kinds[g])
            KIND_AND:  drive_node(g, a);
            KIND_OR:   drive_node(g, o);
            KIND_NAND: drive_node(g, !a);
            KIND_NOR:  drive_node(g, !o);
            KIND_XOR:  drive_node(g, x);
            KIND_NOT:  drive_node(g, !net_val[fin_node[g*MAX_FANIN]]);
            default:   r.status = 1'b1;
          endcase
        end
      end
      default: r.node_value = net_val[gi];
    endcase
    return r;
  endfunction

  // true when an evaluate now touches only table entries that were written
  function automatic bit eval_safe();
    int lim, n, c, g;
    lim = (cfg_inputs > MAX_PRIMARY_INPUTS) ? MAX_PRIMARY_INPUTS : cfg_inputs;
    for (int i = 0; i < lim; i++) begin
      if (!map_ok[i]) return 0;
      n = in_map[i];
      if (!fcnt_ok[n]) return 0;
      c = fout_cnt[n];
      if (c > 1) for (int j = 0; j < c; j++) if (!fout_ok[n*MAX_FANOUT+j]) return 0;
    end
    lim = (cfg_order_len > MAX_GATE_RECORDS) ? MAX_GATE_RECORDS : cfg_order_len;
    for (int i = 0; i < lim; i++) begin
      if (!order_ok[i]) return 0;
      g = order[i];
      if (!kind_ok[g]) return 0;
      c = (fin_cnt[g] < 2) ? 2 : fin_cnt[g];
      for (int p = 0; p < c; p++) if (!fin_ok[g*MAX_FANIN+p]) return 0;
      if (kinds[g] <= KIND_NOT) begin
        if (!fcnt_ok[g]) return 0;
        c = fout_cnt[g];
        if (c > 1) for (int j = 0; j < c; j++) if (!fout_ok[g*MAX_FANOUT+j]) return 0;
      end
    end
    return 1;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report("unexpected item, node_value", out_item_o.node_value, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.node_value !== want.node_value)
          report("node_value", out_item_o.node_value, want.node_value);
        if (out_item_o.status !== want.status)
          report("status", out_item_o.status, want.status);
      end
    end
  end

  // receiver stall pattern: runs of no stall, light stall and heavy stall
  int stall_mode, stall_run;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_mode = $urandom_range(2);
        stall_run = $urandom_range(60, 5);
      end else begin
        stall_run--;
      end
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(3) == 0);
        default: out_stall_i <= ($urandom_range(3) != 0);
      endcase
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results = {pending_results, netlist_response(it)};
    sent_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(12, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // negative field arguments leave that field random
  task automatic put(logic [2:0] act, int gi, int pin, int node, int kind, int cnt, int slot);
    logic [127:0] r;
    in_item_t it;
    r = {$urandom(), $urandom(), $urandom(), $urandom()};
    it = r[$bits(in_item_t)-1:0];
    it.action = act;
    if (gi >= 0) it.gate_index = NODE_W'(gi);
    if (pin >= 0) it.pin_index = 3'(pin);
    if (node >= 0) it.node_index = NODE_W'(node);
    if (kind >= 0) it.gate_kind = 3'(kind);
    if (cnt >= 0) it.pin_count = 4'(cnt);
    if (slot >= 0) it.slot_index = 10'(slot);
    send_item(it);
  endtask

  task automatic evaluate(logic [63:0] vec);
    logic [127:0] r;
    in_item_t it;
    r = {$urandom(), $urandom(), $urandom(), $urandom()};
    it = r[$bits(in_item_t)-1:0];
    it.action = ACT_EVALUATE;
    it.input_vector = vec;
    if (!eval_safe()) it.action = ACT_READ;
    send_item(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // block must be idle: call drain first
  task automatic set_config(int inputs, int order_len);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_INPUT_COUNT;
    cfg_data_i <= CFG_DATA_W'(inputs);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_inputs = 7'(inputs);
    cfg_index_i <= REG_ORDER_LENGTH;
    cfg_data_i <= CFG_DATA_W'(order_len);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_order_len = 11'(order_len);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_state();
    put(ACT_READ, 0, -1, -1, -1, -1, -1);
    put(ACT_READ, MAX_GATE_RECORDS-1, -1, -1, -1, -1, -1);
    evaluate({$urandom(), $urandom()});
    drain();
  endtask

  // records 0 and 1 are inputs, record 0 fans out to 2 and 3; gates 20..27 cover all kinds
  task automatic test_each_kind();
    put(ACT_FANOUT_CNT, 0, -1, -1, -1, 2, -1);
    put(ACT_FANOUT_PIN, 0, 0, 2, -1, -1, -1);
    put(ACT_FANOUT_PIN, 0, 1, 3, -1, -1, -1);
    put(ACT_FANOUT_CNT, 1, -1, -1, -1, 1, -1);
    put(ACT_INPUT_MAP, -1, -1, 0, -1, -1, 0);
    put(ACT_INPUT_MAP, -1, -1, 1, -1, -1, 1);
    for (int k = 0; k < 8; k++) begin
      put(ACT_KIND, 20+k, -1, -1, k, 2, -1);
      put(ACT_FANIN_PIN, 20+k, 0, 2, -1, -1, -1);
      put(ACT_FANIN_PIN, 20+k, 1, 1, -1, -1, -1);
      if (k <= KIND_NOT) put(ACT_FANOUT_CNT, 20+k, -1, -1, -1, 0, -1);
      put(ACT_ORDER, -1, -1, 20+k, -1, -1, k);
    end
    drain();
    set_config(2, 8);
    for (int v = 0; v < 4; v++) begin
      evaluate(v);
      if (v[0]) for (int k = 0; k < 6; k++) put(ACT_READ, 20+k, -1, -1, -1, -1, -1);
    end
    put(ACT_READ, 3, -1, -1, -1, -1, -1);
    drain();
  endtask

  // more input bits mapped, an ignored out-of-range map write, then the empty setup
  task automatic test_long_order();
    for (int i = 2; i < 8; i++)
      put(ACT_INPUT_MAP, -1, -1, i % 2, -1, -1, i);
    put(ACT_INPUT_MAP, -1, -1, -1, -1, -1, $urandom_range(1023, MAX_PRIMARY_INPUTS));
    drain();
    set_config(8, 8);
    evaluate({$urandom(), $urandom()});
    evaluate({$urandom(), $urandom()});
    put(ACT_READ, 22, -1, -1, -1, -1, -1);
    put(ACT_READ, 3, -1, -1, -1, -1, -1);
    drain();
    set_config(0, 0);
    evaluate({$urandom(), $urandom()});
    put(ACT_READ, 20, -1, -1, -1, -1, -1);
    drain();
  endtask

  task automatic build_gate(int g, int base, int span);
    int kind, cnt, n;
    kind = ($urandom_range(9) == 0) ? $urandom_range(KIND_BAD_HI, KIND_BAD_LO)
                                    : $urandom_range(KIND_NOT);
    cnt = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(3);
    put(ACT_KIND, g, -1, -1, kind, cnt, -1);
    n = (cnt > MAX_FANIN) ? MAX_FANIN : ((cnt < 2) ? 2 : cnt);
    for (int p = 0; p < n; p++)
      put(ACT_FANIN_PIN, g, p, base + $urandom_range(span-1), -1, -1, -1);
    cnt = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(2);
    put(ACT_FANOUT_CNT, g, -1, -1, -1, cnt, -1);
    n = (cnt > MAX_FANOUT) ? MAX_FANOUT : cnt;
    if (n > 1) for (int p = 0; p < n; p++)
      put(ACT_FANOUT_PIN, g, p, base + $urandom_range(span-1), -1, -1, -1);
  endtask

  task automatic test_random_netlists();
    int base, gates, olen, inputs, pick;
    while (sent_items < ITEM_BUDGET) begin
      base = $urandom_range(MAX_GATE_RECORDS - 8);
      gates = $urandom_range(5, 3);
      for (int g = 0; g < gates; g++) build_gate(base + g, base, 8);
      olen = $urandom_range(6, 1);
      for (int i = 0; i < olen; i++)
        put(ACT_ORDER, -1, -1, base + $urandom_range(gates-1), -1, -1, i);
      inputs = $urandom_range(4);
      for (int i = 0; i < inputs; i++)
        put(ACT_INPUT_MAP, -1, -1, base + $urandom_range(gates-1), -1, -1, i);
      drain();
      set_config(inputs, olen);
      for (int i = 0; i < 8; i++) begin
        pick = $urandom_range(19);
        if (pick < 8) evaluate({$urandom(), $urandom()});
        else if (pick < 15) put(ACT_READ, base + $urandom_range(7), -1, -1, -1, -1, -1);
        else put(3'($urandom_range(ACT_INPUT_MAP)), -1, -1, -1, -1, -1, -1);
      end
      drain();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_each_kind();
    test_long_order();
    test_random_netlists();
    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

endmodule
